[hw/rtl/lgs_pkg.sv]
// ============================================================================
// lgs_pkg: shared types and constants for the Life generation stencil unit
// Board size limits, register indexes, rule counts and the job record that
// travels from the front end through the queue to the back end.
// ============================================================================
package lgs_pkg;

    // Default board limits (top-level parameter defaults)
    localparam int MAX_COLUMNS_DEF = 1024;
    localparam int MAX_ROWS_DEF    = 1024;

    // Configuration port
    localparam int CFG_DW = 11;
    localparam int CFG_AW = 1;
    localparam logic [CFG_AW-1:0] REG_BOARD_ROWS    = 1'd0;
    localparam logic [CFG_AW-1:0] REG_BOARD_COLUMNS = 1'd1;
    localparam int SIZE_RESET = 1024;

    // B3/S23 rule
    localparam logic [3:0] NBR_BIRTH = 4'd3;
    localparam logic [3:0] NBR_KEEP  = 4'd2;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Which neighbors lie on the board, plus the final-cell flag
    typedef struct packed {
        logic lv;
        logic rv;
        logic tv;
        logic bv;
        logic last;
    } t_edge_mask;

    // One cell to evaluate: 3x3 window (bit = col*3 + row) and its edge mask
    typedef struct packed {
        logic [8:0] win;
        t_edge_mask mask;
    } t_cell_job;

endpackage

[hw/rtl/lgs_ram.sv]
// ============================================================================
// lgs_ram: generic simple dual-port RAM
// One write port and one read port with registered, read-first output.
// ============================================================================
module lgs_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read; a same-address read returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/lgs_front.sv]
// ============================================================================
// lgs_front: input side of the stencil
// Holds the board size registers and raster counters, reads and updates the
// line store, shifts the 3x3 window and classifies each output cell.
// ============================================================================
module lgs_front #(
    parameter int MAX_COLUMNS = lgs_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = lgs_pkg::MAX_ROWS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_wr_en,
    input  logic [lgs_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [lgs_pkg::CFG_DW-1:0]  i_cfg_wdata,
    // cell stream
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_cell_alive,
    input  logic                        i_pad,
    // queue side
    input  logic [$clog2(lgs_pkg::QUEUE_DEPTH+1)-1:0] i_q_count,
    output logic                        o_push,
    output lgs_pkg::t_cell_job          o_job
);

    import lgs_pkg::*;

    localparam int CW   = $clog2(MAX_COLUMNS);
    localparam int CLW  = $clog2(MAX_COLUMNS + 1);
    localparam int RW   = $clog2(MAX_ROWS + 1);
    localparam int IRW  = $clog2(MAX_ROWS + 3);
    localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
    localparam int RST_ROWS = (MAX_ROWS < SIZE_RESET) ? MAX_ROWS : SIZE_RESET;
    localparam int RST_COLS = (MAX_COLUMNS < SIZE_RESET) ? MAX_COLUMNS : SIZE_RESET;

    // zero acts as one, oversize saturates
    function automatic logic [31:0] clamp_size(input logic [CFG_DW-1:0] v, input int maxv);
        logic [31:0] w;
        w = {{(32-CFG_DW){1'b0}}, v};
        if (w == 32'd0) begin
            return 32'd1;
        end else if (w > 32'(maxv)) begin
            return 32'(maxv);
        end else begin
            return w;
        end
    endfunction

    logic [RW-1:0]  r_rows;
    logic [CLW-1:0] r_cols;
    logic [CW-1:0]  r_ic;
    logic [IRW-1:0] r_ir;
    logic [8:0]     r_win;

    // stage 1 (line store data valid)
    logic           r_s1_valid;
    logic [CW-1:0]  r_s1_addr;
    logic           r_s1_x;
    logic           r_s1_emit;
    t_edge_mask     r_s1_mask;
    logic           r_byp;
    logic [1:0]     r_byp_data;

    logic           acc;
    logic [IRW-1:0] rows_x;
    logic           emit_a, emit_b, emit_now;
    logic [IRW-1:0] orow;
    logic [CW-1:0]  ocol;
    t_edge_mask     mask_now;
    logic           x_now;
    logic           col_wrap;
    logic [1:0]     ram_rd, store_rd, ram_wd;
    logic           top, mid;
    logic [8:0]     win_new;
    logic           cfg_rows, cfg_cols;

    assign acc    = i_valid && o_ready;
    assign rows_x = IRW'(r_rows);

    // room for the item in flight plus this one
    assign o_ready = (QCW'(r_s1_valid && r_s1_emit) + i_q_count) < QCW'(QUEUE_DEPTH);

    // classify the cell completed by this item
    always_comb begin
        emit_a = (r_ic != '0) && (r_ir != '0);
        emit_b = (r_ic == '0) && (r_ir > IRW'(1));
        orow   = emit_a ? (r_ir - IRW'(1)) : (r_ir - IRW'(2));
        ocol   = emit_a ? (r_ic - CW'(1)) : CW'(r_cols - CLW'(1));
        emit_now      = (emit_a || emit_b) && (orow < rows_x);
        mask_now.lv   = (ocol != '0);
        mask_now.rv   = (CLW'(ocol) + CLW'(1)) < r_cols;
        mask_now.tv   = (orow != '0);
        mask_now.bv   = (orow + IRW'(1)) < rows_x;
        mask_now.last = emit_now && (orow == rows_x - IRW'(1))
                        && (CLW'(ocol) == r_cols - CLW'(1));
        x_now    = i_cell_alive && !i_pad && (r_ir < rows_x);
        col_wrap = (CLW'(r_ic) + CLW'(1)) == r_cols;
    end

    assign cfg_rows = i_cfg_wr_en && (i_cfg_addr == REG_BOARD_ROWS);
    assign cfg_cols = i_cfg_wr_en && (i_cfg_addr == REG_BOARD_COLUMNS);

    // size registers and raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= RW'(RST_ROWS);
            r_cols <= CLW'(RST_COLS);
            r_ic   <= '0;
            r_ir   <= '0;
        end else if (cfg_rows || cfg_cols) begin
            if (cfg_rows) begin
                r_rows <= RW'(clamp_size(i_cfg_wdata, MAX_ROWS));
            end
            if (cfg_cols) begin
                r_cols <= CLW'(clamp_size(i_cfg_wdata, MAX_COLUMNS));
            end
            r_ic <= '0;
            r_ir <= '0;
        end else if (acc) begin
            if (mask_now.last) begin
                r_ic <= '0;
                r_ir <= '0;
            end else if (col_wrap) begin
                r_ic <= '0;
                if (r_ir < rows_x + IRW'(2)) begin
                    r_ir <= r_ir + IRW'(1);
                end
            end else begin
                r_ic <= r_ic + CW'(1);
            end
        end
    end

    // stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= acc;
        end
    end

    // stage 1 payload and same-address bypass
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_addr <= r_ic;
            r_s1_x    <= x_now;
            r_s1_emit <= emit_now;
            r_s1_mask <= mask_now;
        end
        r_byp      <= r_s1_valid && (r_s1_addr == r_ic);
        r_byp_data <= ram_wd;
    end

    // line store: bit 1 upper row, bit 0 middle row
    lgs_ram #(
        .WIDTH(2),
        .DEPTH(MAX_COLUMNS)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_addr),
        .i_wdata (ram_wd),
        .i_raddr (r_ic),
        .o_rdata (ram_rd)
    );

    always_comb begin
        store_rd = r_byp ? r_byp_data : ram_rd;
        top      = store_rd[1];
        mid      = store_rd[0];
        ram_wd   = {mid, r_s1_x};
        win_new  = {r_s1_x, mid, top, r_win[8:3]};
    end

    // window shift; cleared on restart
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en) begin
            r_win <= '0;
        end else if (r_s1_valid) begin
            r_win <= (r_s1_emit && r_s1_mask.last) ? 9'd0 : win_new;
        end
    end

    assign o_push     = r_s1_valid && r_s1_emit;
    assign o_job.win  = win_new;
    assign o_job.mask = r_s1_mask;

    // counters return to the board origin after the final cell
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && mask_now.last) |=> (r_ic == '0) && (r_ir == '0))
        else $error("counters not cleared after final cell");

    // column counter stays on the board
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CLW'(r_ic) < r_cols)
        else $error("column counter past board width");

endmodule

[hw/rtl/lgs_queue.sv]
// ============================================================================
// lgs_queue: short job queue between front and back
// Register-based FIFO of cell jobs, head visible without a read cycle.
// ============================================================================
module lgs_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  lgs_pkg::t_cell_job   i_job,
    input  logic                 i_pop,
    output logic                 o_valid,
    output lgs_pkg::t_cell_job   o_job,
    output logic [$clog2(lgs_pkg::QUEUE_DEPTH+1)-1:0] o_count
);

    import lgs_pkg::*;

    localparam int PW  = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    t_cell_job       r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [QCW-1:0]  r_cnt;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            r_cnt <= r_cnt + QCW'(i_push) - QCW'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign o_count = r_cnt;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt < QCW'(QUEUE_DEPTH)))
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != '0))
        else $error("job queue underflow");

endmodule

[hw/rtl/lgs_back.sv]
// ============================================================================
// lgs_back: rule evaluation and output register
// Counts on-board live neighbors of the queued window and applies B3/S23.
// ============================================================================
module lgs_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  lgs_pkg::t_cell_job   i_job,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_next_alive,
    output logic                 o_last_cell
);

    import lgs_pkg::*;

    logic       r_valid;
    logic       r_next;
    logic       r_last;
    logic [3:0] cnt;
    logic       nxt;
    t_edge_mask m;
    logic [8:0] w;

    assign o_pop = i_q_valid && (!r_valid || i_ready);

    // neighbor count with board edges masked
    always_comb begin
        m   = i_job.mask;
        w   = i_job.win;
        cnt = 4'(m.lv && m.tv && w[0]) + 4'(m.lv && w[1]) + 4'(m.lv && m.bv && w[2])
            + 4'(m.tv && w[3]) + 4'(m.bv && w[5])
            + 4'(m.rv && m.tv && w[6]) + 4'(m.rv && w[7]) + 4'(m.rv && m.bv && w[8]);
        if (cnt == NBR_BIRTH) begin
            nxt = 1'b1;
        end else if (cnt == NBR_KEEP) begin
            nxt = w[4];
        end else begin
            nxt = 1'b0;
        end
    end

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_next <= nxt;
            r_last <= m.last;
        end
    end

    assign o_valid      = r_valid;
    assign o_next_alive = r_next;
    assign o_last_cell  = r_last;

endmodule

[hw/rtl/life_generation_stencil_unit.sv]
// ============================================================================
// life_generation_stencil_unit: one Life (B3/S23) generation as a stream
// Raster cells in, next-generation cells out one row and one column behind.
// ============================================================================
//
//  channel   direction  fields (low bit up)                 transfer when
//  --------  ---------  ----------------------------------  -------------------------
//  s_axis    in         tdata[0] cell_alive, tuser[0] pad   tvalid && tready
//  m_axis    out        tdata[0] next_alive, tlast last     tvalid && tready
//  cfg       in         addr 0 board_rows, 1 board_columns  i_cfg_wr_en
//
//  One cell per cycle sustained while m_axis accepts; a result leaves after the
//  transfer that completes it through the line store read, queue and output register.
//  The line store is one 2-bit RAM, read and written once per cycle.
//  Reset (synchronous) clears counters, window, queue and output; the line
//  store is not cleared since stale rows are always masked as board edges.
//  s_axis_tready drops only when the four-entry job queue backs up behind a
//  stalled m_axis.
//
module life_generation_stencil_unit #(
    parameter int MAX_COLUMNS = lgs_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = lgs_pkg::MAX_ROWS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration write port
    input  logic                       i_cfg_wr_en,
    input  logic [lgs_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [lgs_pkg::CFG_DW-1:0] i_cfg_wdata,
    // cell input stream
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,   // [0] cell_alive
    input  logic [0:0]                 s_axis_tuser,   // [0] pad
    // next-generation output stream
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [7:0]                 m_axis_tdata,   // [0] next_alive
    output logic                       m_axis_tlast
);

    import lgs_pkg::*;

    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    logic           push, pop, q_valid;
    t_cell_job      push_job, head_job;
    logic [QCW-1:0] q_count;
    logic           next_alive;

    // front end: counters, line store, window, classification
    lgs_front #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .MAX_ROWS   (MAX_ROWS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_cell_alive (s_axis_tdata[0]),
        .i_pad        (s_axis_tuser[0]),
        .i_q_count    (q_count),
        .o_push       (push),
        .o_job        (push_job)
    );

    // job queue
    lgs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (head_job),
        .o_count (q_count)
    );

    // back end: rule and output register
    lgs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_job        (head_job),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_next_alive (next_alive),
        .o_last_cell  (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, next_alive};

endmodule
